>>> rtl/isotp_pkg.sv
package isotp_pkg;

    localparam int ID_W     = 29;
    localparam int LEN_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 4;
    localparam int NMSG_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int FRAME_BYTES = 8;

    localparam logic [ID_W-1:0] FUNC_ADDR_RST = 29'd2015;
    localparam logic [ID_W-1:0] PHYS_ADDR_RST = 29'd2016;
    localparam logic [ID_W-1:0] RESP_ADDR_RST = 29'd2024;
    localparam logic [BYTE_W-1:0] FC_BS_RST    = 8'd0;
    localparam logic [BYTE_W-1:0] FC_STMIN_RST = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_ADDR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FC_BS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FC_STMIN  = 3'd4;

    localparam logic [3:0] PCI_SINGLE = 4'd0;
    localparam logic [3:0] PCI_FIRST  = 4'd1;
    localparam logic [3:0] PCI_CONSEC = 4'd2;

    localparam logic [BYTE_W-1:0] FC_CTS = 8'h30;
    localparam logic [3:0] SF_MAX_LEN = 4'd7;
    localparam logic [NMSG_W-1:0] FF_DATA_BYTES = 3'd6;
    localparam logic [NMSG_W-1:0] CF_DATA_BYTES = 3'd7;
    localparam logic [CNT_W-1:0] FC_REPLY_BYTES = 4'd3;
    localparam logic [CNT_W-1:0] PASS_RESULTS = 4'd8;

    typedef enum logic [2:0] {
        KIND_MSG     = 3'd0,
        KIND_FC      = 3'd1,
        KIND_PASS    = 3'd2,
        KIND_SEQ_ERR = 3'd3,
        KIND_EMPTY   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PLAN_PASS,
        PLAN_SF,
        PLAN_FF,
        PLAN_CF,
        PLAN_SEQ_ERR
    } plan_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_results;
        logic last_item;
    } dp_status_t;

endpackage

>>> rtl/isotp_ctrl.sv
module isotp_ctrl
    import isotp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       in_stall
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.has_results)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if ((!out_valid || !out_stall) && status.last_item)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_EMIT:
            begin
                cmd.emit = !out_valid || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/isotp_dp.sv
module isotp_dp
    import isotp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data,
    input  logic                 bus_select,
    input  logic [ID_W-1:0]      can_id,
    input  logic [BYTE_W-1:0]    byte0,
    input  logic [BYTE_W-1:0]    byte1,
    input  logic [BYTE_W-1:0]    byte2,
    input  logic [BYTE_W-1:0]    byte3,
    input  logic [BYTE_W-1:0]    byte4,
    input  logic [BYTE_W-1:0]    byte5,
    input  logic [BYTE_W-1:0]    byte6,
    input  logic [BYTE_W-1:0]    byte7,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [2:0]           kind,
    output logic                 bus,
    output logic [ID_W-1:0]      frame_id,
    output logic [LEN_W-1:0]     byte_index,
    output logic [BYTE_W-1:0]    byte_value,
    output logic [LEN_W-1:0]     message_length,
    output logic                 message_done,
    output logic                 last
);

    // configuration
    logic [ID_W-1:0]   func_addr_reg;
    logic [ID_W-1:0]   phys_addr_reg;
    logic [ID_W-1:0]   resp_addr_reg;
    logic [BYTE_W-1:0] fc_bs_reg;
    logic [BYTE_W-1:0] fc_stmin_reg;

    // reassembly state
    logic [LEN_W-1:0] exp_len_reg;
    logic [LEN_W-1:0] exp_len_next;
    logic [LEN_W-1:0] rx_count_reg;
    logic [LEN_W-1:0] rx_count_next;
    logic [3:0]       next_seq_reg;
    logic [3:0]       next_seq_next;
    logic             active_reg;
    logic             active_next;

    // latched request and its result plan
    logic [BYTE_W-1:0] frame_reg [FRAME_BYTES];
    logic              bus_reg;
    logic [ID_W-1:0]   id_reg;
    plan_t             plan_reg;
    plan_t             plan_next;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  total_next;
    logic [NMSG_W-1:0] nmsg_reg;
    logic [NMSG_W-1:0] nmsg_next;
    logic [LEN_W-1:0]  base_reg;
    logic [LEN_W-1:0]  base_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              done_flag_reg;
    logic              done_flag_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic              bus_out_reg;
    logic [ID_W-1:0]   frame_id_reg;
    logic [ID_W-1:0]   frame_id_next;
    logic [LEN_W-1:0]  byte_index_reg;
    logic [LEN_W-1:0]  byte_index_next;
    logic [BYTE_W-1:0] byte_value_reg;
    logic [BYTE_W-1:0] byte_value_next;
    logic [LEN_W-1:0]  msg_len_reg;
    logic [LEN_W-1:0]  msg_len_next;
    logic              done_out_reg;
    logic              done_out_next;
    logic              last_out_reg;

    // decode signals
    logic              is_diag;
    logic [3:0]        pci;
    logic [NMSG_W-1:0] sf_len;
    logic [LEN_W-1:0]  ff_len;
    logic [NMSG_W-1:0] ff_n;
    logic [LEN_W-1:0]  cf_rem;
    logic [NMSG_W-1:0] cf_n;

    // emit signals
    logic [2:0]        byte_sel;
    logic [BYTE_W-1:0] sel_byte;
    logic              msg_phase;
    logic [CNT_W-1:0]  fc_j;
    logic              msg_end;
    logic [BYTE_W-1:0] fc_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_addr_reg <= FUNC_ADDR_RST;
            phys_addr_reg <= PHYS_ADDR_RST;
            resp_addr_reg <= RESP_ADDR_RST;
            fc_bs_reg     <= FC_BS_RST;
            fc_stmin_reg  <= FC_STMIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FUNC_ADDR: func_addr_reg <= cfg_data;
                CFG_PHYS_ADDR: phys_addr_reg <= cfg_data;
                CFG_RESP_ADDR: resp_addr_reg <= cfg_data;
                CFG_FC_BS:     fc_bs_reg     <= cfg_data[BYTE_W-1:0];
                CFG_FC_STMIN:  fc_stmin_reg  <= cfg_data[BYTE_W-1:0];
                default:       ;
            endcase
        end
    end

    // request decode
    always_comb
    begin
        is_diag = (can_id == func_addr_reg) || (can_id == phys_addr_reg);
        pci     = byte0[7:4];
        sf_len  = (byte0[3:0] > SF_MAX_LEN) ? SF_MAX_LEN[NMSG_W-1:0] : byte0[NMSG_W-1:0];
        ff_len  = {byte0[3:0], byte1};
        ff_n    = (ff_len < {{(LEN_W-NMSG_W){1'b0}}, FF_DATA_BYTES})
                  ? ff_len[NMSG_W-1:0] : FF_DATA_BYTES;
        cf_rem  = exp_len_reg - rx_count_reg;
        cf_n    = (cf_rem < {{(LEN_W-NMSG_W){1'b0}}, CF_DATA_BYTES})
                  ? cf_rem[NMSG_W-1:0] : CF_DATA_BYTES;

        plan_next      = PLAN_PASS;
        total_next     = PASS_RESULTS;
        nmsg_next      = '0;
        base_next      = '0;
        len_next       = '0;
        done_flag_next = 1'b0;
        exp_len_next   = exp_len_reg;
        rx_count_next  = rx_count_reg;
        next_seq_next  = next_seq_reg;
        active_next    = active_reg;

        if (is_diag)
        begin
            total_next = '0;
            case (pci)
                PCI_SINGLE:
                begin
                    plan_next      = PLAN_SF;
                    nmsg_next      = sf_len;
                    total_next     = (sf_len == '0) ? CNT_W'(1) : {1'b0, sf_len};
                    len_next       = {{(LEN_W-NMSG_W){1'b0}}, sf_len};
                    done_flag_next = 1'b1;
                    active_next    = 1'b0;
                    exp_len_next   = {{(LEN_W-NMSG_W){1'b0}}, sf_len};
                    rx_count_next  = {{(LEN_W-NMSG_W){1'b0}}, sf_len};
                end
                PCI_FIRST:
                begin
                    plan_next      = PLAN_FF;
                    nmsg_next      = ff_n;
                    total_next     = ((ff_n == '0) ? CNT_W'(1) : {1'b0, ff_n})
                                     + FC_REPLY_BYTES;
                    len_next       = ff_len;
                    done_flag_next = (ff_len <= {{(LEN_W-NMSG_W){1'b0}}, FF_DATA_BYTES});
                    exp_len_next   = ff_len;
                    rx_count_next  = {{(LEN_W-NMSG_W){1'b0}}, ff_n};
                    next_seq_next  = 4'd1;
                    active_next    = (ff_len > {{(LEN_W-NMSG_W){1'b0}}, FF_DATA_BYTES});
                end
                PCI_CONSEC:
                begin
                    if (active_reg)
                    begin
                        len_next  = exp_len_reg;
                        base_next = rx_count_reg;
                        if (byte0[3:0] != next_seq_reg)
                        begin
                            plan_next  = PLAN_SEQ_ERR;
                            total_next = CNT_W'(1);
                        end
                        else
                        begin
                            plan_next      = PLAN_CF;
                            nmsg_next      = cf_n;
                            total_next     = {1'b0, cf_n};
                            done_flag_next = (cf_rem == {{(LEN_W-NMSG_W){1'b0}}, cf_n});
                            rx_count_next  = rx_count_reg
                                             + {{(LEN_W-NMSG_W){1'b0}}, cf_n};
                            next_seq_next  = next_seq_reg + 4'd1;
                            if (done_flag_next)
                            begin
                                active_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    total_next = '0;
                end
            endcase
        end
    end

    assign status.has_results = (total_next != '0);
    assign status.last_item   = (idx_reg == (total_reg - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg  <= '0;
            rx_count_reg <= '0;
            next_seq_reg <= '0;
            active_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            exp_len_reg  <= exp_len_next;
            rx_count_reg <= rx_count_next;
            next_seq_reg <= next_seq_next;
            active_reg   <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            frame_reg[0]  <= byte0;
            frame_reg[1]  <= byte1;
            frame_reg[2]  <= byte2;
            frame_reg[3]  <= byte3;
            frame_reg[4]  <= byte4;
            frame_reg[5]  <= byte5;
            frame_reg[6]  <= byte6;
            frame_reg[7]  <= byte7;
            bus_reg       <= bus_select;
            id_reg        <= can_id;
            plan_reg      <= plan_next;
            total_reg     <= total_next;
            nmsg_reg      <= nmsg_next;
            base_reg      <= base_next;
            len_reg       <= len_next;
            done_flag_reg <= done_flag_next;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.emit)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // result generation for the current index
    always_comb
    begin
        byte_sel  = (plan_reg == PLAN_PASS) ? idx_reg[2:0]
                  : ((plan_reg == PLAN_FF) ? 3'd2 : 3'd1) + idx_reg[2:0];
        sel_byte  = frame_reg[byte_sel];
        msg_phase = (idx_reg < {1'b0, nmsg_reg});
        msg_end   = (idx_reg + CNT_W'(1) == {1'b0, nmsg_reg}) && done_flag_reg;
        fc_j      = idx_reg - ((nmsg_reg == '0) ? CNT_W'(1) : {1'b0, nmsg_reg});
        case (fc_j[1:0])
            2'd0:    fc_byte = FC_CTS;
            2'd1:    fc_byte = fc_bs_reg;
            2'd2:    fc_byte = fc_stmin_reg;
            default: fc_byte = '0;
        endcase

        kind_next       = KIND_MSG;
        frame_id_next   = '0;
        byte_index_next = base_reg + {{(LEN_W-CNT_W){1'b0}}, idx_reg};
        byte_value_next = sel_byte;
        msg_len_next    = len_reg;
        done_out_next   = msg_end;

        case (plan_reg)
            PLAN_PASS:
            begin
                kind_next       = KIND_PASS;
                frame_id_next   = id_reg;
                byte_index_next = {{(LEN_W-CNT_W){1'b0}}, idx_reg};
                msg_len_next    = '0;
                done_out_next   = 1'b0;
            end
            PLAN_SF, PLAN_CF, PLAN_FF:
            begin
                if (!msg_phase)
                begin
                    if ((nmsg_reg == '0) && (idx_reg == '0))
                    begin
                        kind_next       = KIND_EMPTY;
                        byte_index_next = '0;
                        byte_value_next = '0;
                        msg_len_next    = '0;
                        done_out_next   = 1'b1;
                    end
                    else
                    begin
                        kind_next       = KIND_FC;
                        frame_id_next   = resp_addr_reg;
                        byte_index_next = {{(LEN_W-2){1'b0}}, fc_j[1:0]};
                        byte_value_next = fc_byte;
                        msg_len_next    = '0;
                        done_out_next   = 1'b0;
                    end
                end
            end
            PLAN_SEQ_ERR:
            begin
                kind_next       = KIND_SEQ_ERR;
                byte_index_next = base_reg;
                byte_value_next = {4'b0, frame_reg[0][3:0]};
                done_out_next   = 1'b0;
            end
            default:
            begin
                kind_next = KIND_MSG;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg       <= kind_next;
            bus_out_reg    <= bus_reg;
            frame_id_reg   <= frame_id_next;
            byte_index_reg <= byte_index_next;
            byte_value_reg <= byte_value_next;
            msg_len_reg    <= msg_len_next;
            done_out_reg   <= done_out_next;
            last_out_reg   <= status.last_item;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign bus            = bus_out_reg;
    assign frame_id       = frame_id_reg;
    assign byte_index     = byte_index_reg;
    assign byte_value     = byte_value_reg;
    assign message_length = msg_len_reg;
    assign message_done   = done_out_reg;
    assign last           = last_out_reg;

endmodule

>>> rtl/isotp_frame_receiver_core.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   bus_select, can_id, byte0..byte7
// out       output     out_valid / out_stall kind, bus, frame_id, byte_index, byte_value,
//                                            message_length, message_done, last
// cfg       input      cfg_write             cfg_index, cfg_data
//
// a request is accepted, then 0 to 9 results are emitted,
// one result per cycle while out_stall does not hold it, through the single output register
// a request with no results frees the input on the next cycle
// in_stall is high while results of the current request are being emitted
// out_stall holds the output register and pauses emission
// reset clears the reassembly state and loads the register defaults
module isotp_frame_receiver_core
    import isotp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 bus_select,
    input  logic [ID_W-1:0]      can_id,
    input  logic [BYTE_W-1:0]    byte0,
    input  logic [BYTE_W-1:0]    byte1,
    input  logic [BYTE_W-1:0]    byte2,
    input  logic [BYTE_W-1:0]    byte3,
    input  logic [BYTE_W-1:0]    byte4,
    input  logic [BYTE_W-1:0]    byte5,
    input  logic [BYTE_W-1:0]    byte6,
    input  logic [BYTE_W-1:0]    byte7,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           kind,
    output logic                 bus,
    output logic [ID_W-1:0]      frame_id,
    output logic [LEN_W-1:0]     byte_index,
    output logic [BYTE_W-1:0]    byte_value,
    output logic [LEN_W-1:0]     message_length,
    output logic                 message_done,
    output logic                 last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    isotp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    isotp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .bus_select     (bus_select),
        .can_id         (can_id),
        .byte0          (byte0),
        .byte1          (byte1),
        .byte2          (byte2),
        .byte3          (byte3),
        .byte4          (byte4),
        .byte5          (byte5),
        .byte6          (byte6),
        .byte7          (byte7),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .kind           (kind),
        .bus            (bus),
        .frame_id       (frame_id),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .message_length (message_length),
        .message_done   (message_done),
        .last           (last)
    );

    // a taken result that is not the last is followed at once by the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("result sequence broken");

    // no new request while results of the current one are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> in_stall)
        else $error("input open during emission");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_done) |->
            (kind == KIND_MSG || kind == KIND_EMPTY))
        else $error("message_done on wrong kind");

endmodule
